[hdl/json_string_unescape_utf8_assert.svh]
// ----------------------------------------------------------------------------
// JSON string unescaper assertion macros
// Shared property wrappers for the decoder blocks; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define JSU_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("jsu assertion failed");
// Next-cycle implication, disabled during reset.
`define JSU_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("jsu assertion failed");
`else
`define JSU_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define JSU_ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif

`endif

[hdl/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// JSON string unescaper package
// Types, character codes, status and error codes, and the UTF-8 encoder.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Decoder modes. In the four hex modes bit 0 marks a bad digit seen.
    typedef enum logic [2:0] {
        M_BODY     = 3'd0,
        M_ESC      = 3'd1,
        M_HEX      = 3'd2,
        M_HEX_BAD  = 3'd3,
        M_WAIT_BS  = 3'd4,
        M_WAIT_U   = 3'd5,
        M_LOW      = 3'd6,
        M_LOW_BAD  = 3'd7
    } t_mode;

    typedef logic [1:0] t_status;
    localparam t_status ST_DATA  = 2'd0;
    localparam t_status ST_CLOSE = 2'd1;
    localparam t_status ST_ERR   = 2'd2;

    typedef logic [3:0] t_err;
    localparam t_err E_NONE      = 4'd0;
    localparam t_err E_UNTERM    = 4'd1;
    localparam t_err E_CTRL      = 4'd2;
    localparam t_err E_UNTERM_ESC = 4'd3;
    localparam t_err E_BAD_ESC   = 4'd4;
    localparam t_err E_TRUNC_HEX = 4'd5;
    localparam t_err E_BAD_HEX   = 4'd6;
    localparam t_err E_LONE_HIGH = 4'd7;
    localparam t_err E_BAD_LOW   = 4'd8;

    // Characters of the escape syntax.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    // Decoded values of the single-letter escapes.
    localparam logic [7:0] VAL_BS = 8'h08;
    localparam logic [7:0] VAL_FF = 8'h0C;
    localparam logic [7:0] VAL_LF = 8'h0A;
    localparam logic [7:0] VAL_CR = 8'h0D;
    localparam logic [7:0] VAL_HT = 8'h09;

    // Top six bits of the high and low surrogate ranges.
    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    // Decoder state kept between input beats; only the low ten bits of the
    // high surrogate carry information.
    typedef struct packed {
        t_mode       mode;
        logic [1:0]  dcnt;
        logic [15:0] accum;
        logic [9:0]  high;
    } t_state;

    localparam t_state STATE_RESET = '{mode: M_BODY, dcnt: 2'd0, accum: 16'd0, high: 10'd0};

    // All results caused by one input beat.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        t_status         status;
        t_err            err;
        logic [2:0]      cnt;
    } t_bundle;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
    } t_utf8;

    // Hex digit value; a bad digit reads as all ones with the flag set.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h1F;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b0, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // One code point to one to four UTF-8 bytes, first byte in lane 0.
    function automatic t_utf8 utf8_encode(input logic [20:0] cp);
        t_utf8 u;
        u.bytes = '0;
        if (cp < 21'h80) begin
            u.cnt = 3'd1;
            u.bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            u.cnt = 3'd2;
            u.bytes[0] = {3'b110, cp[10:6]};
            u.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            u.cnt = 3'd3;
            u.bytes[0] = {4'b1110, cp[15:12]};
            u.bytes[1] = {2'b10, cp[11:6]};
            u.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            u.cnt = 3'd4;
            u.bytes[0] = {5'b11110, cp[20:18]};
            u.bytes[1] = {2'b10, cp[17:12]};
            u.bytes[2] = {2'b10, cp[11:6]};
            u.bytes[3] = {2'b10, cp[5:0]};
        end
        return u;
    endfunction

endpackage

[hdl/jsu_decode.sv]
// ----------------------------------------------------------------------------
// JSU decode step
// Combinational next-state and result logic for one input beat.
// ----------------------------------------------------------------------------
module jsu_decode (
    input  logic [7:0]      i_data_byte,
    input  logic            i_end_of_text,
    input  jsu_pkg::t_state i_state,
    output jsu_pkg::t_state o_state,
    output jsu_pkg::t_bundle o_bundle
);
    import jsu_pkg::*;

    logic [4:0]  hex;
    logic [15:0] acc_n;
    logic        bad_now;
    logic        do_fail;
    t_err        fail_code;
    t_utf8       enc;
    logic        do_enc;
    logic [20:0] enc_cp;
    t_state      nxt;
    t_bundle     res;

    assign hex     = hex_nibble(i_data_byte);
    assign acc_n   = {i_state.accum[11:0], hex[3:0]};
    assign bad_now = i_state.mode[0] | hex[4];
    assign enc     = utf8_encode(enc_cp);

    // One step of the unescaper.
    always_comb begin
        nxt       = i_state;
        do_fail   = 1'b0;
        fail_code = E_NONE;
        do_enc    = 1'b0;
        enc_cp    = {5'd0, acc_n};
        res       = '{bytes: '0, status: ST_DATA, err: E_NONE, cnt: 3'd0};

        if (i_end_of_text) begin
            do_fail = 1'b1;
            unique case (i_state.mode)
                M_BODY:              fail_code = E_UNTERM;
                M_ESC:               fail_code = E_UNTERM_ESC;
                M_WAIT_BS, M_WAIT_U: fail_code = E_LONE_HIGH;
                default:             fail_code = E_TRUNC_HEX;
            endcase
        end else begin
            unique case (i_state.mode)
                M_BODY: begin
                    if (i_data_byte == CH_QUOTE) begin
                        nxt        = STATE_RESET;
                        res.status = ST_CLOSE;
                        res.cnt    = 3'd1;
                    end else if (i_data_byte < CTRL_LIMIT) begin
                        do_fail   = 1'b1;
                        fail_code = E_CTRL;
                    end else if (i_data_byte == CH_BSLASH) begin
                        nxt.mode = M_ESC;
                    end else begin
                        res.bytes[0] = i_data_byte;
                        res.cnt      = 3'd1;
                    end
                end
                M_ESC: begin
                    nxt.mode = M_BODY;
                    res.cnt  = 3'd1;
                    unique case (i_data_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: res.bytes[0] = i_data_byte;
                        CH_LC_B: res.bytes[0] = VAL_BS;
                        CH_LC_F: res.bytes[0] = VAL_FF;
                        CH_LC_N: res.bytes[0] = VAL_LF;
                        CH_LC_R: res.bytes[0] = VAL_CR;
                        CH_LC_T: res.bytes[0] = VAL_HT;
                        CH_LC_U: begin
                            nxt.mode  = M_HEX;
                            nxt.dcnt  = 2'd0;
                            nxt.accum = 16'd0;
                            res.cnt   = 3'd0;
                        end
                        default: begin
                            do_fail   = 1'b1;
                            fail_code = E_BAD_ESC;
                        end
                    endcase
                end
                M_WAIT_BS: begin
                    if (i_data_byte != CH_BSLASH) begin
                        do_fail   = 1'b1;
                        fail_code = E_LONE_HIGH;
                    end else begin
                        nxt.mode = M_WAIT_U;
                    end
                end
                M_WAIT_U: begin
                    if (i_data_byte != CH_LC_U) begin
                        do_fail   = 1'b1;
                        fail_code = E_LONE_HIGH;
                    end else begin
                        nxt.mode  = M_LOW;
                        nxt.dcnt  = 2'd0;
                        nxt.accum = 16'd0;
                    end
                end
                default: begin
                    // Hex digit modes: a bad digit is only reported after four.
                    nxt.accum = acc_n;
                    if (i_state.dcnt != 2'd3) begin
                        nxt.dcnt = 2'(i_state.dcnt + 2'd1);
                        nxt.mode = t_mode'({i_state.mode[2:1], bad_now});
                    end else if (bad_now) begin
                        do_fail   = 1'b1;
                        fail_code = E_BAD_HEX;
                    end else if (i_state.mode == M_HEX) begin
                        nxt.dcnt  = 2'd0;
                        nxt.accum = 16'd0;
                        if (acc_n[15:10] == SURR_HIGH_TAG) begin
                            nxt.high = acc_n[9:0];
                            nxt.mode = M_WAIT_BS;
                        end else begin
                            nxt.mode = M_BODY;
                            do_enc   = 1'b1;
                        end
                    end else if (acc_n[15:10] != SURR_LOW_TAG) begin
                        do_fail   = 1'b1;
                        fail_code = E_BAD_LOW;
                    end else begin
                        nxt    = STATE_RESET;
                        do_enc = 1'b1;
                        enc_cp = SUPP_BASE + {1'b0, i_state.high, acc_n[9:0]};
                    end
                end
            endcase
        end

        // Code point output.
        if (do_enc) begin
            res.bytes = enc.bytes;
            res.cnt   = enc.cnt;
        end

        // Any error clears the state and gives a single error result.
        if (do_fail) begin
            nxt = STATE_RESET;
            res = '{bytes: '0, status: ST_ERR, err: fail_code, cnt: 3'd1};
        end
    end

    assign o_state  = nxt;
    assign o_bundle = res;

endmodule

[hdl/jsu_outbuf.sv]
// ----------------------------------------------------------------------------
// JSU output buffer
// Holds the results of one input beat and hands them out one per beat.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_assert.svh"

module jsu_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  jsu_pkg::t_bundle i_bundle,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic [7:0]       o_out_byte,
    output logic [1:0]       o_status,
    output logic [3:0]       o_error_code,
    output logic             o_last_of_run,
    output logic             o_free
);
    import jsu_pkg::*;

    logic [2:0]      r_left, n_left;
    logic [3:0][7:0] r_bytes, n_bytes;
    t_status         r_status, n_status;
    t_err            r_err, n_err;
    logic            take;

    // Room for a new bundle when empty or when the last result leaves now.
    assign take   = (r_left != 3'd0) && !i_out_stall;
    assign o_free = (r_left == 3'd0) || ((r_left == 3'd1) && take);

    // Load a new bundle or shift the next byte into lane 0.
    always_comb begin
        n_left   = r_left;
        n_bytes  = r_bytes;
        n_status = r_status;
        n_err    = r_err;
        if (i_load) begin
            n_left   = i_bundle.cnt;
            n_bytes  = i_bundle.bytes;
            n_status = i_bundle.status;
            n_err    = i_bundle.err;
        end else if (take) begin
            n_left  = 3'(r_left - 3'd1);
            n_bytes = {8'h00, r_bytes[3:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
        end else begin
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes  <= n_bytes;
        r_status <= n_status;
        r_err    <= n_err;
    end

    assign o_out_valid   = (r_left != 3'd0);
    assign o_out_byte    = r_bytes[0];
    assign o_status      = r_status;
    assign o_error_code  = r_err;
    assign o_last_of_run = (r_left == 3'd1);

    // A bundle never holds more than one UTF-8 sequence.
    `JSU_ASSERT_IMP(a_left_max, i_clk, i_rst_n, 1'b1, r_left <= 3'd4)
    // Close and error results always stand alone.
    `JSU_ASSERT_IMP(a_ctrl_single, i_clk, i_rst_n, o_out_valid && (r_status != ST_DATA), r_left == 3'd1)
    // An error code goes with the error status and nothing else.
    `JSU_ASSERT_IMP(a_err_code, i_clk, i_rst_n, o_out_valid, (r_status == ST_ERR) == (r_err != E_NONE))

endmodule

[hdl/json_string_unescape_utf8.sv]
// ----------------------------------------------------------------------------
// JSON string unescaper with UTF-8 output
// Decodes the body of a JSON string byte by byte and emits UTF-8 beats.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one text byte per beat,
//   or an end-of-text marker. Output channel (o_out_valid / i_out_stall)
//   carries decoded bytes, a close marker, or an error with its code.
//   o_last_of_run marks the final output beat caused by an input beat.
//   The first result of an input beat appears in the cycle after the beat
//   is taken. An input beat that yields one result or none is taken every
//   cycle while the receiver does not stall. A beat that yields several
//   results (a UTF-8 sequence of up to four bytes) occupies the single
//   output buffer until its last result leaves, and the next input beat
//   is taken in the cycle that last result leaves.
//   When the receiver stalls, the buffered result holds and o_in_stall rises
//   once the buffer has no room for the next beat.
//   Synchronous active-low reset returns the decoder to the string body and
//   empties the output buffer. After a close or an error the next byte
//   starts a new string body.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_assert.svh"

module json_string_unescape_utf8 (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_text,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_status,
    output logic [3:0] o_error_code,
    output logic       o_last_of_run
);
    import jsu_pkg::*;

    t_state  r_state, n_state;
    t_bundle bundle;
    logic    free;
    logic    accept;

    assign o_in_stall = !free;
    assign accept     = i_in_valid && free;

    // Decode step on the incoming beat.
    jsu_decode u_decode (
        .i_data_byte  (i_data_byte),
        .i_end_of_text(i_end_of_text),
        .i_state      (r_state),
        .o_state      (n_state),
        .o_bundle     (bundle)
    );

    // Decoder state advances on each accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Result register and serializer.
    jsu_outbuf u_outbuf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_bundle     (bundle),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_byte   (o_out_byte),
        .o_status     (o_status),
        .o_error_code (o_error_code),
        .o_last_of_run(o_last_of_run),
        .o_free       (free)
    );

    // A pending high surrogate exists only while waiting for its partner.
    `JSU_ASSERT_IMP(a_high_clear, i_clk, i_rst_n, !r_state.mode[2], r_state.high == 10'd0)
    // Digit count is only nonzero inside a hex group.
    `JSU_ASSERT_IMP(a_dcnt_idle, i_clk, i_rst_n, (r_state.mode == M_BODY) || (r_state.mode == M_ESC) || (r_state.mode == M_WAIT_BS) || (r_state.mode == M_WAIT_U), r_state.dcnt == 2'd0)
    // A closing quote in the body shows up as a close marker next cycle.
    `JSU_ASSERT_NXT(a_close_out, i_clk, i_rst_n, accept && !i_end_of_text && (r_state.mode == M_BODY) && (i_data_byte == CH_QUOTE), o_out_valid && (o_status == ST_CLOSE))

endmodule
